// File: rtl/core/cbmd_pkg.sv
`default_nettype none

package cbmd_pkg;

   localparam int ANGLE_BITS_DEF = 16;

   localparam int RAD_W  = 31;
   localparam int HPS_W  = 16;
   localparam int AVG_W  = 16;
   localparam int HZ_W   = 31;
   localparam int CSR_DW = 31;
   localparam int CSR_AW = 2;

   typedef enum logic [CSR_AW-1:0] {
      CSR_RADIUS   = 2'd0,
      CSR_HALF_PHI = 2'd1,
      CSR_AVG_PHI  = 2'd2,
      CSR_HALF_Z   = 2'd3
   } csr_idx_type;

   localparam logic [RAD_W-1:0] RADIUS_RST   = 31'd4096;
   localparam logic [HPS_W-1:0] HALF_PHI_RST = 16'd32768;
   localparam logic [AVG_W-1:0] AVG_PHI_RST  = 16'd0;
   localparam logic [HZ_W-1:0]  HALF_Z_RST   = 31'd0;

   localparam int DIV_STAGES    = 64;
   localparam int HORNER_STAGES = 5;
   localparam int ROOT_STAGES   = 32;

   // floor(2^31 / pi)
   localparam logic [29:0] INV_PI_Q31 = 30'd683565275;

   localparam logic [31:0] SIN_C11 = 32'd3864;

   // constant terms of the Horner steps, innermost first
   localparam logic [31:0] HORNER_SUB [0:HORNER_STAGES-1] = '{
      32'd172272, 32'd5026995, 32'd85569306, 32'd693598668, 32'd1686629713
   };

   localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] SAT_MIN = 32'h8000_0000;

endpackage

`default_nettype wire

// File: rtl/core/cylinder_bounds_min_distance.sv
// Throughput: one item per cycle while the output is not stalled; the 64-stage restoring
// divider and the 32-stage square root are fully pipelined.
// A stalled output holds the whole pipeline in place.
// Reset clears all valid bits and loads the configuration registers with defaults.
`default_nettype none

module cylinder_bounds_min_distance #(
   parameter int ANGLE_BITS = cbmd_pkg::ANGLE_BITS_DEF
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire  signed [31:0]           req_loc_rphi,
   input  wire  signed [31:0]           req_loc_z,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output logic signed [31:0]           rsp_distance,
   input  wire                          csr_write,
   input  wire  [cbmd_pkg::CSR_AW-1:0]  csr_index,
   input  wire  [cbmd_pkg::CSR_DW-1:0]  csr_wdata
);

   localparam int AB     = ANGLE_BITS;
   localparam int DW     = ((AB > 16) ? AB : 16) + 2;
   localparam int NDIV   = cbmd_pkg::DIV_STAGES;
   localparam int NHOR   = cbmd_pkg::HORNER_STAGES;
   localparam int NROOT  = cbmd_pkg::ROOT_STAGES;
   localparam int NSTG   = 1 + NDIV + 3 + 1 + NHOR + 4 + NROOT + 1;
   localparam logic [AB-1:0] API_A = {1'b1, {(AB-1){1'b0}}};
   localparam logic [31:0]   API_W = 32'(API_A);

   function automatic logic [31:0] sat35(input logic signed [34:0] v);
      logic [31:0] r;
      if (!v[34] && v[33:31] != 3'b000) begin
         r = cbmd_pkg::SAT_MAX;
      end else if (v[34] && v[33:31] != 3'b111) begin
         r = cbmd_pkg::SAT_MIN;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // configuration
   logic [cbmd_pkg::RAD_W-1:0] radius_ff;
   logic [cbmd_pkg::HPS_W-1:0] half_phi_ff;
   logic [cbmd_pkg::AVG_W-1:0] avg_phi_ff;
   logic [cbmd_pkg::HZ_W-1:0]  half_z_ff;
   logic [cbmd_pkg::RAD_W-1:0] r_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff   <= cbmd_pkg::RADIUS_RST;
         half_phi_ff <= cbmd_pkg::HALF_PHI_RST;
         avg_phi_ff  <= cbmd_pkg::AVG_PHI_RST;
         half_z_ff   <= cbmd_pkg::HALF_Z_RST;
      end else if (csr_write) begin
         unique case (cbmd_pkg::csr_idx_type'(csr_index))
            cbmd_pkg::CSR_RADIUS:   radius_ff   <= csr_wdata;
            cbmd_pkg::CSR_HALF_PHI: half_phi_ff <= csr_wdata[cbmd_pkg::HPS_W-1:0];
            cbmd_pkg::CSR_AVG_PHI:  avg_phi_ff  <= csr_wdata[cbmd_pkg::AVG_W-1:0];
            cbmd_pkg::CSR_HALF_Z:   half_z_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign r_eff = (radius_ff == '0) ? 31'd1 : radius_ff;

   // pipeline control
   logic            adv;
   logic [NSTG-1:0] vld_ff;

   assign adv       = !vld_ff[NSTG-1] || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = vld_ff[NSTG-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NSTG-2:0], req_valid};
      end
   end

   // input stage and divider
   logic [31:0]        rphi_abs_in;
   logic [31:0]        z_abs_in;
   logic signed [33:0] sz_in;

   logic [30:0]        dv_rem_ff  [0:NDIV];
   logic [63:0]        dv_quot_ff [0:NDIV];
   logic [31:0]        dv_mag_ff  [0:NDIV];
   logic               dv_neg_ff  [0:NDIV];
   logic signed [33:0] dv_sz_ff   [0:NDIV];
   logic [30:0]        dv_rem_in  [1:NDIV];
   logic [63:0]        dv_quot_in [1:NDIV];

   assign rphi_abs_in = req_loc_rphi[31] ? 32'(-req_loc_rphi) : req_loc_rphi;
   assign z_abs_in    = req_loc_z[31] ? 32'(-req_loc_z) : req_loc_z;
   assign sz_in       = $signed({2'b00, z_abs_in}) - $signed({3'b000, half_z_ff});

   for (genvar k = 1; k <= NDIV; k++) begin : g_div
      logic        nb;
      logic [31:0] sh;
      logic        ge;
      if (NDIV - k >= 32) begin : g_bit
         assign nb = dv_mag_ff[k-1][NDIV-k-32];
      end else begin : g_zero
         assign nb = 1'b0;
      end
      assign sh            = {dv_rem_ff[k-1], nb};
      assign ge            = sh >= {1'b0, r_eff};
      assign dv_rem_in[k]  = ge ? 31'(sh - {1'b0, r_eff}) : sh[30:0];
      assign dv_quot_in[k] = {dv_quot_ff[k-1][62:0], ge};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_rem_ff[0]  <= '0;
         dv_quot_ff[0] <= '0;
         dv_mag_ff[0]  <= rphi_abs_in;
         dv_neg_ff[0]  <= req_loc_rphi[31];
         dv_sz_ff[0]   <= sz_in;
         for (int i = 1; i <= NDIV; i++) begin
            dv_rem_ff[i]  <= dv_rem_in[i];
            dv_quot_ff[i] <= dv_quot_in[i];
            dv_mag_ff[i]  <= dv_mag_ff[i-1];
            dv_neg_ff[i]  <= dv_neg_ff[i-1];
            dv_sz_ff[i]   <= dv_sz_ff[i-1];
         end
      end
   end

   // angle: q * floor(2^31/pi) mod 2^64, split in halves
   logic [61:0]        pl_in, ph_full;
   logic [61:0]        pl_ff;
   logic [31:0]        ph_ff;
   logic               p1_neg_ff;
   logic signed [33:0] p1_sz_ff;

   assign pl_in   = dv_quot_ff[NDIV][31:0] * cbmd_pkg::INV_PI_Q31;
   assign ph_full = dv_quot_ff[NDIV][63:32] * cbmd_pkg::INV_PI_Q31;

   logic [63:0]        asum;
   logic [AB-1:0]      ang_raw, ang_in;
   logic [AB-1:0]      ang_ff;
   logic signed [33:0] p2_sz_ff;

   assign asum    = 64'(pl_ff) + {ph_ff, 32'h0};
   assign ang_raw = asum[63 -: AB];
   assign ang_in  = p1_neg_ff ? {AB{1'b0}} - ang_raw : ang_raw;

   logic [31:0]          avg32;
   logic [AB-1:0]        d_a, d_neg, d2;
   logic signed [DW-1:0] diff, adiff;
   logic [30:0]          at_in;
   logic                 full_in;

   assign avg32 = {{16{avg_phi_ff[15]}}, avg_phi_ff};
   assign d_a   = ang_ff - avg32[AB-1:0];
   assign d_neg = {AB{1'b0}} - d_a;
   assign d2    = (d_a > API_A) ? d_neg : d_a;
   assign diff  = $signed({{(DW-AB){1'b0}}, d2}) - $signed({{(DW-16){1'b0}}, half_phi_ff});
   assign adiff = diff[DW-1] ? -diff : diff;
   assign at_in = {adiff[AB-1:0], {(31-AB){1'b0}}};
   assign full_in = {16'h0, half_phi_ff} >= API_W;

   always_ff @(posedge clock) begin
      if (adv) begin
         pl_ff     <= pl_in;
         ph_ff     <= ph_full[31:0];
         p1_neg_ff <= dv_neg_ff[NDIV];
         p1_sz_ff  <= dv_sz_ff[NDIV];
         ang_ff    <= ang_in;
         p2_sz_ff  <= p1_sz_ff;
      end
   end

   // sine: index 0 holds |t|, index 1 holds t^2, then Horner steps
   logic [30:0]        sc_at_ff   [0:NHOR+1];
   logic [30:0]        sc_t2_ff   [1:NHOR+1];
   logic               sc_tneg_ff [0:NHOR+1];
   logic               sc_full_ff [0:NHOR+1];
   logic signed [33:0] sc_sz_ff   [0:NHOR+1];
   logic [31:0]        hp_ff      [2:NHOR+1];
   logic [31:0]        hp_in      [2:NHOR+1];
   logic [61:0]        t2_full;

   assign t2_full = sc_at_ff[0] * sc_at_ff[0];

   for (genvar j = 2; j <= NHOR + 1; j++) begin : g_hor
      logic [62:0] prod;
      if (j == 2) begin : g_first
         assign prod = cbmd_pkg::SIN_C11 * sc_t2_ff[j-1];
      end else begin : g_next
         assign prod = hp_ff[j-1] * sc_t2_ff[j-1];
      end
      assign hp_in[j] = cbmd_pkg::HORNER_SUB[j-2] - prod[61:30];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sc_at_ff[0]   <= at_in;
         sc_tneg_ff[0] <= diff[DW-1];
         sc_full_ff[0] <= full_in;
         sc_sz_ff[0]   <= p2_sz_ff;
         sc_t2_ff[1]   <= t2_full[60:30];
         for (int i = 1; i <= NHOR + 1; i++) begin
            sc_at_ff[i]   <= sc_at_ff[i-1];
            sc_tneg_ff[i] <= sc_tneg_ff[i-1];
            sc_full_ff[i] <= sc_full_ff[i-1];
            sc_sz_ff[i]   <= sc_sz_ff[i-1];
         end
         for (int i = 2; i <= NHOR + 1; i++) begin
            sc_t2_ff[i] <= sc_t2_ff[i-1];
            hp_ff[i]    <= hp_in[i];
         end
      end
   end

   // s = at * p, sf = r * s, decision and squares, sum
   logic [62:0]        sprod;
   logic [31:0]        s_ff;
   logic               s_tneg_ff, s_full_ff;
   logic signed [33:0] s_sz_ff;

   assign sprod = sc_at_ff[NHOR+1] * hp_ff[NHOR+1];

   logic [62:0]        fprod;
   logic [34:0]        fmag;
   logic signed [34:0] sf_ff;
   logic               f_full_ff;
   logic signed [33:0] f_sz_ff;

   assign fprod = r_eff * s_ff;
   assign fmag  = {1'b0, fprod[62:29]};

   logic signed [34:0] sz35;
   logic               nonpos, big, root_in;
   logic [31:0]        alt_in;
   logic [61:0]        sqf_in, sqz_in, sqf_ff, sqz_ff;
   logic               q_root_ff;
   logic [31:0]        q_alt_ff;

   assign sz35   = {f_sz_ff[33], f_sz_ff};
   assign nonpos = sf_ff[34] || sf_ff == '0 || f_sz_ff[33] || f_sz_ff == '0;
   assign big    = sf_ff[33:31] != 3'b000 || f_sz_ff[32:31] != 2'b00;
   assign root_in = !f_full_ff && !nonpos && !big;
   assign sqf_in = sf_ff[30:0] * sf_ff[30:0];
   assign sqz_in = f_sz_ff[30:0] * f_sz_ff[30:0];

   always_comb begin
      priority if (f_full_ff) begin
         alt_in = sat35(sz35);
      end else if (nonpos) begin
         alt_in = sat35((sf_ff > sz35) ? sf_ff : sz35);
      end else begin
         alt_in = cbmd_pkg::SAT_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s_ff      <= sprod[61:30];
         s_tneg_ff <= sc_tneg_ff[NHOR+1];
         s_full_ff <= sc_full_ff[NHOR+1];
         s_sz_ff   <= sc_sz_ff[NHOR+1];
         sf_ff     <= s_tneg_ff ? -$signed(fmag) : $signed(fmag);
         f_full_ff <= s_full_ff;
         f_sz_ff   <= s_sz_ff;
         sqf_ff    <= sqf_in;
         sqz_ff    <= sqz_in;
         q_root_ff <= root_in;
         q_alt_ff  <= alt_in;
      end
   end

   // square root, one result bit per stage
   logic [62:0] rt_v_ff    [0:NROOT];
   logic [62:0] rt_res_ff  [0:NROOT];
   logic        rt_root_ff [0:NROOT];
   logic [31:0] rt_alt_ff  [0:NROOT];
   logic [62:0] rt_v_in    [1:NROOT];
   logic [62:0] rt_res_in  [1:NROOT];

   for (genvar k = 1; k <= NROOT; k++) begin : g_root
      localparam logic [63:0] BIT = 64'd1 << (62 - 2 * (k - 1));
      logic [63:0] trial;
      logic        ge;
      assign trial        = {1'b0, rt_res_ff[k-1]} + BIT;
      assign ge           = {1'b0, rt_v_ff[k-1]} >= trial;
      assign rt_v_in[k]   = ge ? 63'(rt_v_ff[k-1] - trial[62:0]) : rt_v_ff[k-1];
      assign rt_res_in[k] = ge ? 63'((rt_res_ff[k-1] >> 1) + BIT[62:0])
                               : (rt_res_ff[k-1] >> 1);
   end

   logic [62:0] res_fin;
   logic [31:0] dist_in;
   logic [31:0] dist_ff;

   assign res_fin = rt_res_ff[NROOT];
   assign dist_in = !rt_root_ff[NROOT] ? rt_alt_ff[NROOT] :
                    (res_fin[62:31] != '0) ? cbmd_pkg::SAT_MAX : {1'b0, res_fin[30:0]};

   always_ff @(posedge clock) begin
      if (adv) begin
         rt_v_ff[0]    <= 63'(sqf_ff) + 63'(sqz_ff);
         rt_res_ff[0]  <= '0;
         rt_root_ff[0] <= q_root_ff;
         rt_alt_ff[0]  <= q_alt_ff;
         for (int i = 1; i <= NROOT; i++) begin
            rt_v_ff[i]    <= rt_v_in[i];
            rt_res_ff[i]  <= rt_res_in[i];
            rt_root_ff[i] <= rt_root_ff[i-1];
            rt_alt_ff[i]  <= rt_alt_ff[i-1];
         end
         dist_ff <= dist_in;
      end
   end

   assign rsp_distance = dist_ff;

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
`default_nettype none

module tb;

   localparam int ANGLE_BITS  = 16;
   localparam int PIPE_DEPTH  = 111;
   localparam int STALL_LIMIT = 6000;
   localparam logic [63:0] ANGLE_MASK = (64'd1 << ANGLE_BITS) - 64'd1;
   localparam logic [63:0] ANGLE_PI   = 64'd1 << (ANGLE_BITS - 1);
   localparam logic [63:0] INV_PI     = 64'd683565275;
   localparam logic [63:0] C1 = 64'd1686629713, C3 = 64'd693598668, C5 = 64'd85569306;
   localparam logic [63:0] C7 = 64'd5026995, C9 = 64'd172272, C11 = 64'd3864;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   wire                          req_ready;
   logic signed [31:0]           req_loc_rphi = '0;
   logic signed [31:0]           req_loc_z = '0;
   wire                          rsp_valid;
   logic                         rsp_ready = 1'b0;
   wire signed [31:0]            rsp_distance;
   logic                         csr_write = 1'b0;
   cbmd_pkg::csr_idx_type        csr_index = cbmd_pkg::CSR_RADIUS;
   logic [cbmd_pkg::CSR_DW-1:0]  csr_wdata = '0;

   logic [cbmd_pkg::RAD_W-1:0]   cyl_radius;
   logic [cbmd_pkg::HPS_W-1:0]   cyl_half_phi;
   logic [cbmd_pkg::AVG_W-1:0]   cyl_avg_phi;
   logic [cbmd_pkg::HZ_W-1:0]    cyl_half_z;

   logic signed [31:0] expected_distance [$];
   int                 mismatches = 0;
   int                 idle_cycles = 0;
   int                 burst_left = 0;
   int                 stall_mode = 0;
   int                 cycle_count = 0;

   cylinder_bounds_min_distance DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_loc_rphi(req_loc_rphi), .req_loc_z(req_loc_z),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_distance(rsp_distance),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return v[31:0];
   endfunction

   function automatic logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] res;
      logic [63:0] b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic logic [63:0] sine_q30(logic [63:0] at);
      logic [63:0] t2;
      logic [63:0] p;
      t2 = (at * at) >> 30;
      p = C9 - ((C11 * t2) >> 30);
      p = C7 - ((p * t2) >> 30);
      p = C5 - ((p * t2) >> 30);
      p = C3 - ((p * t2) >> 30);
      p = C1 - ((p * t2) >> 30);
      return (at * p) >> 30;
   endfunction

   function automatic logic signed [31:0] sector_distance(logic signed [31:0] rphi,
                                                         logic signed [31:0] z);
      longint      zl, sz, sf, diff;
      logic [63:0] r, mag, q, ang, avg, d, at, s;
      zl = z;
      sz = (zl < 0 ? -zl : zl) - longint'(cyl_half_z);
      r = (cyl_radius == 0) ? 64'd1 : 64'(cyl_radius);
      if (64'(cyl_half_phi) >= ANGLE_PI) return clamp32(sz);
      mag = (rphi < 0) ? 64'(-longint'(rphi)) : 64'(longint'(rphi));
      q = (mag << 32) / r;
      ang = (q * INV_PI) >> (64 - ANGLE_BITS);
      if (rphi < 0) ang = (64'd0 - ang) & ANGLE_MASK;
      avg = {{48{cyl_avg_phi[15]}}, cyl_avg_phi} & ANGLE_MASK;
      d = (ang - avg) & ANGLE_MASK;
      if (d > ANGLE_PI) d = (ANGLE_MASK + 64'd1) - d;
      diff = (longint'(d) - longint'(cyl_half_phi)) * (longint'(1) << (31 - ANGLE_BITS));
      at = (diff < 0) ? 64'(-diff) : 64'(diff);
      s = sine_q30(at);
      sf = longint'((r * s) >> 29);
      if (diff < 0) sf = -sf;
      if (sf <= 0 || sz <= 0) return clamp32(sf > sz ? sf : sz);
      if (sf >= 64'sd2147483648 || sz >= 64'sd2147483648) return 32'sh7FFF_FFFF;
      return clamp32(longint'(int_sqrt(64'(sf) * 64'(sf) + 64'(sz) * 64'(sz))));
   endfunction

   // receiver stall pattern, picked at random from four modes
   always @(negedge clock) begin
      cycle_count++;
      if (cycle_count % 300 == 0) stall_mode = $urandom_range(0, 3);
      unique case (stall_mode)
         0: rsp_ready = 1'b1;
         1: rsp_ready = ($urandom_range(0, 1) == 1);
         2: rsp_ready = (cycle_count % 7) < 3;
         default: rsp_ready = ($urandom_range(0, 9) != 0);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_distance.size() == 0) begin
            $display("%0t: unexpected distance, expected none, actual %0d",
                     $time, rsp_distance);
            mismatches++;
         end else begin
            if (rsp_distance !== expected_distance[0]) begin
               $display("%0t: distance mismatch, expected %0d, actual %0d",
                        $time, expected_distance[0], rsp_distance);
               mismatches++;
            end
            void'(expected_distance.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("timeout at %0t", $time);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic write_reg(cbmd_pkg::csr_idx_type idx, logic [cbmd_pkg::CSR_DW-1:0] value);
      @(negedge clock);
      csr_write = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_write = 1'b0;
      unique case (idx)
         cbmd_pkg::CSR_RADIUS:   cyl_radius = value[cbmd_pkg::RAD_W-1:0];
         cbmd_pkg::CSR_HALF_PHI: cyl_half_phi = value[cbmd_pkg::HPS_W-1:0];
         cbmd_pkg::CSR_AVG_PHI:  cyl_avg_phi = value[cbmd_pkg::AVG_W-1:0];
         default:                cyl_half_z = value[cbmd_pkg::HZ_W-1:0];
      endcase
   endtask

   task automatic set_sector(logic [30:0] r, logic [15:0] hp, logic [15:0] av,
                             logic [30:0] hz);
      write_reg(cbmd_pkg::CSR_RADIUS, r);
      write_reg(cbmd_pkg::CSR_HALF_PHI, 31'(hp));
      write_reg(cbmd_pkg::CSR_AVG_PHI, 31'(av));
      write_reg(cbmd_pkg::CSR_HALF_Z, hz);
   endtask

   task automatic send_item(logic signed [31:0] rphi, logic signed [31:0] z);
      @(negedge clock);
      req_valid = 1'b1;
      req_loc_rphi = rphi;
      req_loc_z = z;
      do @(posedge clock); while (!req_ready);
      expected_distance.push_back(sector_distance(rphi, z));
   endtask

   // drop valid for a random gap between bursts
   task automatic pace_sender();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
         return;
      end
      burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(50, 200) : $urandom_range(1, 12);
      gap = $urandom_range(1, 10);
      @(negedge clock);
      req_valid = 1'b0;
      repeat (gap - 1) @(negedge clock);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_distance.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 10) @(posedge clock);
   endtask

   function automatic logic signed [31:0] pick_rphi();
      longint span;
      unique case ($urandom_range(0, 3))
         0: return $urandom;
         1: return $signed($urandom_range(0, 4095)) - 2048;
         default: begin
            span = longint'(cyl_radius) * 7;
            if (span > 64'sd2147483647) span = 64'sd2147483647;
            if (span < 1) span = 1;
            return clamp32(longint'($urandom_range(0, 32'(span))) *
                           ($urandom_range(0, 1) ? 1 : -1));
         end
      endcase
   endfunction

   function automatic logic signed [31:0] pick_z();
      longint hz;
      unique case ($urandom_range(0, 2))
         0: return $urandom;
         default: begin
            hz = longint'(cyl_half_z) + longint'($urandom_range(0, 1 << 16)) - 32768;
            return clamp32($urandom_range(0, 1) ? hz : -hz);
         end
      endcase
   endfunction

   task automatic test_full_sector_defaults();
      send_item(0, 0);
      send_item(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      send_item(32'sh8000_0000, 32'sh8000_0000);
      send_item(-1, -1);
      send_item(1, 1);
      drain();
   endtask

   task automatic test_sector_edges();
      set_sector(31'd4096, 16'd8192, 16'd0, 31'd4096);
      send_item(0, 0);
      send_item(32'sd6434, 32'sd8192);
      send_item(-32'sd6434, -32'sd8192);
      send_item(32'sd12868, 32'sd20000);
      send_item(32'sh7FFF_FFFF, 32'sh8000_0000);
      send_item(32'sh8000_0000, 32'sh7FFF_FFFF);
      drain();
      // zero radius treated as one, half sector zero, opposite center
      set_sector(31'd0, 16'd0, 16'h8000, 31'h7FFF_FFFF);
      send_item(32'sd3, 32'sh8000_0000);
      send_item(-32'sd3, 32'sd0);
      drain();
      // large overshoot saturates in the root case
      set_sector(31'h7FFF_FFFF, 16'd1, 16'h7FFF, 31'd0);
      send_item(32'sh8000_0000, 32'sh8000_0000);
      send_item(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      send_item(32'sh4000_0000, 32'sh4000_0000);
      drain();
      // half sector above pi counts as full
      set_sector(31'd4096, 16'hFFFF, 16'h1234, 31'd100);
      send_item(32'sd5000, -32'sd50);
      send_item(32'sh8000_0000, 32'sh7FFF_FFFF);
      drain();
   endtask

   task automatic run_random(int count);
      repeat (count) begin
         send_item(pick_rphi(), pick_z());
         pace_sender();
      end
   endtask

   task automatic test_random_sectors();
      for (int phase = 0; phase < 8; phase++) begin
         unique case (phase)
            0: set_sector(31'd4096, 16'd32767, 16'h8000, 31'd0);
            1: set_sector(31'h7FFF_FFFF, 16'd0, 16'h7FFF, 31'h7FFF_FFFF);
            2: set_sector(31'd1, 16'd16384, 16'h0000, 31'd1);
            default: set_sector(
               31'($urandom_range(1, 32'h7FFF_FFFF) >> $urandom_range(0, 24)),
               16'($urandom_range(0, 36000)), 16'($urandom),
               31'($urandom_range(0, 32'h7FFF_FFFF) >> $urandom_range(0, 24)));
         endcase
         run_random(120);
         // hold until the pipeline is empty mid-phase
         drain();
         run_random(110);
         drain();
      end
   endtask

   initial begin
      cyl_radius = cbmd_pkg::RADIUS_RST;
      cyl_half_phi = cbmd_pkg::HALF_PHI_RST;
      cyl_avg_phi = cbmd_pkg::AVG_PHI_RST;
      cyl_half_z = cbmd_pkg::HALF_Z_RST;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_full_sector_defaults();
      test_sector_edges();
      test_random_sectors();
      drain();
      if (mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

`default_nettype wire
